### hdl/ctpl_pkg.sv
// Package for the coordinate text path length block: constants, codes and shared types.
package ctpl_pkg;

   // Character codes
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_POINT   = 8'h2E;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   // Field and datapath widths
   localparam int COORD_W  = 11;               // -999..999 tenths
   localparam int DELTA_W  = COORD_W + 1;
   localparam int SQ_W     = 22;               // one squared delta
   localparam int SUMSQ_W  = SQ_W + 1;         // dx^2 + dy^2
   localparam int FRAC_W   = 16;               // radicand scaling
   localparam int RAD_W    = 40;               // even width, holds SUMSQ_W + FRAC_W
   localparam int ROOT_W   = RAD_W / 2;
   localparam int REM_W    = ROOT_W + 2;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int STEP_W   = $clog2(ROOT_STEPS);
   localparam int COUNT_W  = 11;
   localparam int LEN_W    = 32;

   localparam logic [COUNT_W-1:0] MAX_POINTS = COUNT_W'(1024);
   localparam logic [LEN_W-1:0]   LEN_MAX    = {LEN_W{1'b1}};
   localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(ROOT_STEPS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_ROOT,
      ST_ACC
   } ctl_state_type;

   typedef struct packed {
      logic accept_char;
      logic accept_end;
      logic mul_x;
      logic mul_y;
      logic root_step;
      logic accumulate;
   } ctl_cmd_type;

   typedef struct packed {
      logic seg_start;   // presented character, if taken, closes a point with a previous one
      logic root_last;
      logic rsp_full;
   } dp_status_type;

endpackage

### hdl/ctpl_ctrl.sv
// Controller state machine for the coordinate text path length block.
module ctpl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_is_end,
   output logic                   req_stall,
   input  ctpl_pkg::dp_status_type status,
   output ctpl_pkg::ctl_cmd_type   cmd
);
   import ctpl_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          idle;
   logic          take_char;

   assign idle      = (state_ff == ST_IDLE);
   assign take_char = idle && req_valid && !req_is_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take_char && status.seg_start) state_in = ST_MUL_X;
         end
         ST_MUL_X: state_in = ST_MUL_Y;
         ST_MUL_Y: state_in = ST_ROOT;
         ST_ROOT: begin
            if (status.root_last) state_in = ST_ACC;
         end
         ST_ACC:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            // an end request waits while the previous result is untaken
            req_stall       = req_is_end && status.rsp_full;
            cmd.accept_char = take_char;
            cmd.accept_end  = req_valid && req_is_end && !status.rsp_full;
         end
         ST_MUL_X: cmd.mul_x      = 1'b1;
         ST_MUL_Y: cmd.mul_y      = 1'b1;
         ST_ROOT:  cmd.root_step  = 1'b1;
         ST_ACC:   cmd.accumulate = 1'b1;
         default:  cmd            = '0;
      endcase
   end

endmodule

### hdl/ctpl_datapath.sv
// Datapath: text parser, point registers, shared multiplier, bit-pair square root, sums.
module ctpl_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [7:0]                          req_char_code,
   input  ctpl_pkg::ctl_cmd_type               cmd,
   output ctpl_pkg::dp_status_type             status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ctpl_pkg::COUNT_W-1:0]        rsp_point_count,
   output logic [ctpl_pkg::LEN_W-1:0]          rsp_path_length
);
   import ctpl_pkg::*;

   // parser state
   logic                      negative_ff, negative_in;
   logic [3:0]                tens_ff, tens_in;
   logic [3:0]                units_ff, units_in;
   logic [3:0]                tenths_ff, tenths_in;
   logic                      expect_tenths_ff, expect_tenths_in;
   logic                      want_y_ff, want_y_in;
   logic signed [COORD_W-1:0] pending_x_ff, pending_x_in;
   logic signed [COORD_W-1:0] prev_x_ff, prev_x_in;
   logic signed [COORD_W-1:0] prev_y_ff, prev_y_in;
   logic                      have_prev_ff, have_prev_in;
   logic [COUNT_W-1:0]        points_ff, points_in;
   logic [LEN_W-1:0]          length_ff, length_in;

   // arithmetic
   logic signed [DELTA_W-1:0] dx_ff, dx_in;
   logic signed [DELTA_W-1:0] dy_ff, dy_in;
   logic [SQ_W-1:0]           sq_ff, sq_in;
   logic [RAD_W-1:0]          rad_ff, rad_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [ROOT_W-1:0]         root_ff, root_in;
   logic [STEP_W-1:0]         step_ff, step_in;

   // result
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic [LEN_W-1:0]          rsp_len_ff, rsp_len_in;

   // combinational helpers
   logic                         is_digit, is_sep;
   logic [3:0]                   digit;
   logic [9:0]                   mag;
   logic signed [COORD_W-1:0]    value;
   logic signed [DELTA_W-1:0]    mul_op;
   logic signed [2*DELTA_W-1:0]  product;
   logic [SUMSQ_W-1:0]           sum_sq;
   logic [REM_W+1:0]             rem_sh, trial;
   logic [LEN_W:0]               len_sum;

   assign is_digit = req_char_code inside {[CHAR_ZERO:CHAR_NINE]};
   assign is_sep   = (req_char_code == CHAR_SPACE) || (req_char_code == CHAR_NEWLINE);
   assign digit    = 4'(req_char_code - CHAR_ZERO);
   assign mag      = 10'(tens_ff) * 10'd100 + 10'(units_ff) * 10'd10 + 10'(tenths_ff);
   assign value    = negative_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

   assign mul_op  = cmd.mul_x ? dx_ff : dy_ff;
   assign product = mul_op * mul_op;
   assign sum_sq  = SUMSQ_W'(sq_ff) + SUMSQ_W'(product[SQ_W-1:0]);

   assign rem_sh  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign len_sum = (LEN_W+1)'(length_ff) + (LEN_W+1)'(root_ff);

   assign status.seg_start = !expect_tenths_ff && is_sep && want_y_ff && have_prev_ff;
   assign status.root_last = (step_ff == LAST_STEP);
   assign status.rsp_full  = rsp_valid_ff;

   always_comb begin
      negative_in      = negative_ff;
      tens_in          = tens_ff;
      units_in         = units_ff;
      tenths_in        = tenths_ff;
      expect_tenths_in = expect_tenths_ff;
      want_y_in        = want_y_ff;
      pending_x_in     = pending_x_ff;
      prev_x_in        = prev_x_ff;
      prev_y_in        = prev_y_ff;
      have_prev_in     = have_prev_ff;
      points_in        = points_ff;
      length_in        = length_ff;
      dx_in            = dx_ff;
      dy_in            = dy_ff;
      sq_in            = sq_ff;
      rad_in           = rad_ff;
      rem_in           = rem_ff;
      root_in          = root_ff;
      step_in          = step_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_len_in       = rsp_len_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;

      if (cmd.accept_end) begin
         rsp_count_in     = points_ff;
         rsp_len_in       = length_ff;
         rsp_valid_in     = 1'b1;
         negative_in      = 1'b0;
         tens_in          = '0;
         units_in         = '0;
         tenths_in        = '0;
         expect_tenths_in = 1'b0;
         want_y_in        = 1'b0;
         pending_x_in     = '0;
         prev_x_in        = '0;
         prev_y_in        = '0;
         have_prev_in     = 1'b0;
         points_in        = '0;
         length_in        = '0;
      end else if (cmd.accept_char) begin
         if (expect_tenths_ff) begin
            // character after the point; a non-digit is swallowed
            if (is_digit) tenths_in = digit;
            expect_tenths_in = 1'b0;
         end else if (is_sep) begin
            if (!want_y_ff) begin
               pending_x_in = value;
               want_y_in    = 1'b1;
            end else begin
               dx_in        = DELTA_W'(pending_x_ff) - DELTA_W'(prev_x_ff);
               dy_in        = DELTA_W'(value) - DELTA_W'(prev_y_ff);
               prev_x_in    = pending_x_ff;
               prev_y_in    = value;
               have_prev_in = 1'b1;
               want_y_in    = 1'b0;
               if (points_ff < MAX_POINTS) points_in = points_ff + COUNT_W'(1);
            end
            negative_in = 1'b0;
            tens_in     = '0;
            units_in    = '0;
            tenths_in   = '0;
         end else if (req_char_code == CHAR_POINT) begin
            expect_tenths_in = 1'b1;
         end else if (req_char_code == CHAR_MINUS) begin
            negative_in = 1'b1;
         end else if (is_digit) begin
            tens_in  = units_ff;
            units_in = digit;
         end
      end

      if (cmd.mul_x) begin
         sq_in = product[SQ_W-1:0];
      end
      if (cmd.mul_y) begin
         rad_in  = RAD_W'({sum_sq, {FRAC_W{1'b0}}});
         rem_in  = '0;
         root_in = '0;
         step_in = '0;
      end
      if (cmd.root_step) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         step_in = step_ff + STEP_W'(1);
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_sh);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.accumulate) begin
         length_in = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         negative_ff      <= 1'b0;
         tens_ff          <= '0;
         units_ff         <= '0;
         tenths_ff        <= '0;
         expect_tenths_ff <= 1'b0;
         want_y_ff        <= 1'b0;
         pending_x_ff     <= '0;
         prev_x_ff        <= '0;
         prev_y_ff        <= '0;
         have_prev_ff     <= 1'b0;
         points_ff        <= '0;
         length_ff        <= '0;
         step_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         negative_ff      <= negative_in;
         tens_ff          <= tens_in;
         units_ff         <= units_in;
         tenths_ff        <= tenths_in;
         expect_tenths_ff <= expect_tenths_in;
         want_y_ff        <= want_y_in;
         pending_x_ff     <= pending_x_in;
         prev_x_ff        <= prev_x_in;
         prev_y_ff        <= prev_y_in;
         have_prev_ff     <= have_prev_in;
         points_ff        <= points_in;
         length_ff        <= length_in;
         step_ff          <= step_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sq_ff        <= sq_in;
      rad_ff       <= rad_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      rsp_count_ff <= rsp_count_in;
      rsp_len_ff   <= rsp_len_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_count = rsp_count_ff;
   assign rsp_path_length = rsp_len_ff;

endmodule

### hdl/coordinate_text_path_length.sv
// Top level of the coordinate text path length block.
//
// Takes coordinate text one character per request and sums the Euclidean length of the
// polyline it describes. Numbers are signed decimals with up to two integer digits and one
// tenths digit; a space or newline ends a number, numbers pair as x then y, and other bytes
// are ignored. An end request returns the point count (saturating at 1024) and the path
// length in tenths with 8 fraction bits (saturating at 2^32-1), then clears all state.
// Sequence: a character request is taken while idle. A y separator that closes a point after the
// first one then runs the one shared multiplier (dx^2, then dy^2 with the add), the
// two-bits-per-cycle square root over a 40-bit radicand, and the saturating accumulate;
// req_stall is high meanwhile. An end request loads the result register; further character
// requests are taken while that result waits, but a second end request is held off until
// the first result has gone.
module coordinate_text_path_length (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_char_code,
   input  logic                         req_is_end,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ctpl_pkg::COUNT_W-1:0] rsp_point_count,
   output logic [ctpl_pkg::LEN_W-1:0]   rsp_path_length
);
   import ctpl_pkg::*;

   ctl_cmd_type   cmd;     // controller to datapath
   dp_status_type status;  // datapath to controller

   // sequencer: idle / square dx / square dy / root steps / accumulate
   ctpl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_is_end (req_is_end),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // parser, point registers, arithmetic and the result register
   ctpl_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_char_code   (req_char_code),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_point_count (rsp_point_count),
      .rsp_path_length (rsp_path_length)
   );

endmodule

### verif/path_length_checker.sv
// Checker for the coordinate text path length block: tracks requests, predicts results, compares.
`timescale 1ns / 100ps

module path_length_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [7:0]                   req_char_code,
   input  logic                         req_is_end,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [ctpl_pkg::COUNT_W-1:0] rsp_point_count,
   input  logic [ctpl_pkg::LEN_W-1:0]   rsp_path_length,
   output int                           fail_count,
   output int                           awaited_count
);
   import ctpl_pkg::*;

   typedef struct packed {
      logic [COUNT_W-1:0] points;
      logic [LEN_W-1:0]   length;
   } path_summary_type;

   path_summary_type expected_summaries[$];

   // parser state
   bit                        minus_seen    = 1'b0;
   logic [3:0]                tens          = '0;
   logic [3:0]                units         = '0;
   logic [3:0]                tenths        = '0;
   bit                        tenths_due    = 1'b0;
   bit                        want_y        = 1'b0;
   logic signed [COORD_W-1:0] held_x        = '0;
   // path state
   logic signed [COORD_W-1:0] last_x        = '0;
   logic signed [COORD_W-1:0] last_y        = '0;
   bit                        have_last     = 1'b0;
   logic [COUNT_W-1:0]        points_parsed = '0;
   logic [LEN_W-1:0]          length_acc    = '0;
   int                        errors        = 0;

   // floor(sqrt((dx^2 + dy^2) * 2^16)), one root bit at a time
   function automatic longint segment_length(input int dx, input int dy);
      longint radicand;
      longint root;
      longint trial;
      radicand = (longint'(dx * dx) + longint'(dy * dy)) << FRAC_W;
      root     = 0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= radicand)
            root = trial;
      end
      return root;
   endfunction

   task automatic clear_number();
      minus_seen = 1'b0;
      tens       = '0;
      units      = '0;
      tenths     = '0;
      tenths_due = 1'b0;
   endtask

   task automatic clear_path();
      clear_number();
      want_y        = 1'b0;
      held_x        = '0;
      last_x        = '0;
      last_y        = '0;
      have_last     = 1'b0;
      points_parsed = '0;
      length_acc    = '0;
   endtask

   task automatic close_point(input logic signed [COORD_W-1:0] y);
      longint sum;
      if (have_last) begin
         sum = longint'(length_acc)
               + segment_length(int'(held_x) - int'(last_x), int'(y) - int'(last_y));
         length_acc = (sum > longint'(LEN_MAX)) ? LEN_MAX : LEN_W'(sum);
      end
      last_x    = held_x;
      last_y    = y;
      have_last = 1'b1;
      if (points_parsed < MAX_POINTS)
         points_parsed++;
   endtask

   task automatic take_byte(input logic [7:0] c, input logic is_end);
      int                        mag;
      logic signed [COORD_W-1:0] coord;
      if (is_end) begin
         expected_summaries.push_back('{points_parsed, length_acc});
         clear_path();
      end else if (tenths_due) begin
         // byte after a point is always consumed, digit or not
         if (c >= CHAR_ZERO && c <= CHAR_NINE)
            tenths = 4'(c - CHAR_ZERO);
         tenths_due = 1'b0;
      end else if (c == CHAR_SPACE || c == CHAR_NEWLINE) begin
         mag   = tens * 100 + units * 10 + tenths;
         coord = COORD_W'(minus_seen ? -mag : mag);
         if (!want_y) begin
            held_x = coord;
            want_y = 1'b1;
         end else begin
            close_point(coord);
            want_y = 1'b0;
         end
         clear_number();
      end else if (c == CHAR_POINT) begin
         tenths_due = 1'b1;
      end else if (c == CHAR_MINUS) begin
         minus_seen = 1'b1;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         tens  = units;
         units = 4'(c - CHAR_ZERO);
      end
   endtask

   always @(posedge clock) begin : watch
      path_summary_type due;
      if (reset) begin
         clear_path();
         expected_summaries.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_summaries.size() == 0) begin
               $display("%0t: unexpected result, count %0d length 0x%08h", $time,
                        rsp_point_count, rsp_path_length);
               errors++;
            end else begin
               due = expected_summaries.pop_front();
               if (rsp_point_count !== due.points) begin
                  $display("%0t: point count expected %0d actual %0d", $time,
                           due.points, rsp_point_count);
                  errors++;
               end
               if (rsp_path_length !== due.length) begin
                  $display("%0t: path length expected 0x%08h actual 0x%08h", $time,
                           due.length, rsp_path_length);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall)
            take_byte(req_char_code, req_is_end);
      end
      fail_count    <= errors;
      awaited_count <= expected_summaries.size();
   end

endmodule

### verif/tb_top.sv
// Testbench top for the coordinate text path length block: clock, reset, stimulus, verdict.
`timescale 1ns / 100ps

module tb_top;
   import ctpl_pkg::*;

   localparam int RANDOM_ITEMS    = 1180;
   localparam int CORNER_REP      = 4;     // two points per pass, widest steps
   localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
   localparam int IDLE_LIMIT      = 2000;  // cycles with no request or result taken
   localparam int DRAIN_CYCLES    = 40;    // margin beyond the segment latency

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic [7:0]          req_char_code   = '0;
   logic                req_is_end      = 1'b0;
   logic                rsp_stall       = 1'b0;
   logic                req_stall;
   logic                rsp_valid;
   logic [COUNT_W-1:0]  rsp_point_count;
   logic [LEN_W-1:0]    rsp_path_length;
   int                  fail_count;
   int                  awaited_count;

   // stimulus controls
   bit gaps_on     = 1'b1;  // sender idles between requests
   int burst_left  = 0;     // requests left in a stretch without idling
   int items_sent  = 0;
   bit pressure_go = 1'b0;  // receiver may start its long hold-off

   always #1 clock = ~clock;

   coordinate_text_path_length i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_is_end      (req_is_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_point_count (rsp_point_count),
      .rsp_path_length (rsp_path_length)
   );

   path_length_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_is_end      (req_is_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_point_count (rsp_point_count),
      .rsp_path_length (rsp_path_length),
      .fail_count      (fail_count),
      .awaited_count   (awaited_count)
   );

   // One request: optional idle gap, then hold valid until the block takes it.
   // Valid stays high on return so back-to-back requests need no second assignment.
   task automatic put_request(input logic [7:0] c, input logic is_end);
      int gap;
      int r;
      gap = 0;
      if (gaps_on) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 3)
               burst_left = $urandom_range(30, 100);
            else if (r < 50)
               gap = 0;
            else if (r < 88)
               gap = $urandom_range(1, 3);
            else if (r < 98)
               gap = $urandom_range(4, 12);
            else
               gap = $urandom_range(20, 60);
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      req_is_end    <= is_end;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++)
         put_request(s[i], 1'b0);
   endtask

   function automatic logic [7:0] random_digit();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // a text byte, now and then preceded by a random noise byte
   task automatic put_byte(input logic [7:0] c);
      if ($urandom_range(0, 24) == 0)
         put_request(8'($urandom_range(0, 255)), 1'b0);
      put_request(c, 1'b0);
   endtask

   // one number: optional minus, 0..5 digits (shifting past two), maybe a stray minus,
   // maybe a point with a digit or a junk byte, then a separator
   task automatic put_coordinate();
      int digits;
      int r;
      if ($urandom_range(0, 3) == 0)
         put_byte(CHAR_MINUS);
      r = $urandom_range(0, 99);
      digits = (r < 10) ? 0 : (r < 85) ? $urandom_range(1, 2) : $urandom_range(3, 5);
      for (int i = 0; i < digits; i++)
         put_byte(random_digit());
      if ($urandom_range(0, 9) == 0)
         put_byte(CHAR_MINUS);
      if ($urandom_range(0, 1)) begin
         put_byte(CHAR_POINT);
         put_byte(($urandom_range(0, 7) != 0) ? random_digit() : 8'($urandom_range(0, 255)));
      end
      put_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_NEWLINE);
   endtask

   // a well-formed path with random content, sometimes with a trailing lone x or a
   // half-typed number, closed by an end request with a random byte
   task automatic put_random_path();
      int pts;
      int r;
      r   = $urandom_range(0, 99);
      pts = (r < 70) ? $urandom_range(0, 4) : (r < 95) ? $urandom_range(5, 12)
                                                       : $urandom_range(13, 40);
      for (int k = 0; k < 2 * pts; k++)
         put_coordinate();
      if ($urandom_range(0, 5) == 0)
         put_coordinate();
      if ($urandom_range(0, 5) == 0) begin
         put_byte(CHAR_MINUS);
         put_byte(random_digit());
      end
      put_request(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // Directed cases:
   //  - three digits keep the last two, point digit gives tenths (123.4 -> 23.4)
   //  - minus zero is zero
   //  - unknown letter ignored, point followed by a non-digit swallows it
   //  - empty number between two separators counts as zero
   //  - extreme bytes 0x00 and 0xFF as unknown characters, and as end bytes
   //  - minus after the digits still negates; lone x discarded at end
   //  - end request straight after an end (empty path)
   task automatic run_directed();
      put_text("123.4 -0\n9a.x  ");
      put_request(8'hFF, 1'b0);
      put_request(8'h00, 1'b0);
      put_request(8'h00, 1'b1);
      put_text("5-\n");
      put_request(8'hFF, 1'b1);
      put_request(8'hA5, 1'b1);
   endtask

   // Zig-zag between opposite corners: largest deltas and the widest radicand
   task automatic run_corners();
      for (int k = 0; k < CORNER_REP; k++) begin
         put_text("-99.9 -99.9 ");
         put_text("99.9 99.9\n");
      end
      put_request(8'h5A, 1'b1);
   endtask

   // Receiver: random stall stretches, some with no stall at all, and one long hold-off
   // once the random phase starts so that a second end request backs up the sender.
   initial begin : receiver
      int  len;
      int  r;
      bit  held;
      bit  level;
      held = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         r = $urandom_range(0, 99);
         if (pressure_go && !held) begin
            held  = 1'b1;
            level = 1'b1;
            len   = HOLD_CYCLES;
         end else if (r < 8) begin
            level = 1'b0;
            len   = $urandom_range(20, 80);
         end else if (r < 95) begin
            level = ($urandom_range(0, 2) == 0);
            len   = $urandom_range(1, 3);
         end else begin
            level = 1'b1;
            len   = $urandom_range(10, 40);
         end
         rsp_stall <= level;
         repeat (len) @(posedge clock);
      end
   end

   // Watchdog: ends the run if neither channel moves for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle = 0;
         else
            idle++;
      end
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin : stimulus
      int base;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // no idling here, keeps the run short
      gaps_on = 1'b0;
      run_corners();
      gaps_on = 1'b1;

      pressure_go = 1'b1;
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS)
         put_random_path();
      req_valid <= 1'b0;

      // let the checker register the last end request before polling
      @(posedge clock);
      while (awaited_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
